/* sv/grsm_pkg.sv */
package grsm_pkg;

  // Field widths fixed by the word formats
  localparam int CMD_W   = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 13;
  localparam int REG_W   = 7;
  localparam int IDX_W   = 1;

  // Register reset values
  localparam logic [REG_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [REG_W-1:0] COL_COUNT_RST = 7'd64;

  // Masking character and count ceiling
  localparam logic [CHAR_W-1:0]  MASK_CHAR   = 8'h2A;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 13'd8191;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [IDX_W-1:0] REG_COL_COUNT = 1'b1;

  // Result kinds
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_WORD = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SETUP,
    ST_CMP,
    ST_MASK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] char_value;
    logic              word_last;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic [CHAR_W-1:0]  cell_value;
    logic [COUNT_W-1:0] match_count;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic start_search;
    logic issue;
    logic next_start;
    logic hit;
    logic mask_wr;
    logic load_read;
    logic load_done;
    logic clear_word;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic search_empty;
    logic mismatch;
    logic chk_last;
    logic k_room;
    logic mask_last;
    logic last_start;
  } dp_sts_t;

endpackage

/* sv/grsm_ram.sv */
module grsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/grsm_dp.sv */
module grsm_dp #(
  parameter int ROWS_MAX = 64,
  parameter int COLS_MAX = 64,
  parameter int WORD_MAX = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [grsm_pkg::IDX_W-1:0]              cfg_idx_i,
  input  logic [grsm_pkg::REG_W-1:0]              cfg_data_i,
  input  grsm_pkg::in_word_t                      in_word_i,
  input  grsm_pkg::ctrl_cmd_t                     cmd_i,
  output grsm_pkg::dp_sts_t                       sts_o,
  output grsm_pkg::out_word_t                     out_word_o
);

  import grsm_pkg::*;

  localparam int GD    = ROWS_MAX * COLS_MAX;
  localparam int GA_W  = (GD > 1) ? $clog2(GD) : 1;
  localparam int RN_W  = $clog2(ROWS_MAX + 1);
  localparam int RX_W  = (RN_W > REG_W) ? RN_W : REG_W;
  localparam int CN_W  = $clog2(COLS_MAX + 1);
  localparam int CX_W  = (CN_W > REG_W) ? CN_W : REG_W;
  localparam int WL_W  = $clog2(WORD_MAX + 1);
  localparam int WA_W  = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int SX_W  = (CX_W > WL_W) ? CX_W : WL_W;
  localparam int AD_W  = 9;

  logic [REG_W-1:0]   row_count_q, col_count_q;
  logic [WL_W-1:0]    wlen_q, wlen_d;
  logic [RX_W-1:0]    row_q, row_d;
  logic [CX_W-1:0]    col_q, col_d;
  logic [WL_W-1:0]    k_q, k_d;
  logic [COUNT_W-1:0] hits_q, hits_d;
  logic               chk_q;
  logic               rd_oor_q;
  out_word_t          out_q;

  logic [RX_W-1:0]    rows_ext, rows_eff;
  logic [CX_W-1:0]    cols_ext, cols_eff;
  logic [SX_W-1:0]    cmax;
  logic               col_last, row_last, word_room, in_grid;
  logic [GA_W-1:0]    in_addr, scan_addr;
  logic               is_load, is_word, is_read;

  logic               g_we, g_re;
  logic [GA_W-1:0]    g_waddr, g_raddr;
  logic [CHAR_W-1:0]  g_wdata, g_rdata;
  logic               w_we;
  logic [CHAR_W-1:0]  w_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_COUNT: row_count_q <= cfg_data_i;
        REG_COL_COUNT: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clipped scan extents
  assign rows_ext = RX_W'(row_count_q);
  assign cols_ext = CX_W'(col_count_q);
  assign rows_eff = (rows_ext > RX_W'(ROWS_MAX)) ? RX_W'(ROWS_MAX) : rows_ext;
  assign cols_eff = (cols_ext > CX_W'(COLS_MAX)) ? CX_W'(COLS_MAX) : cols_ext;
  assign cmax     = SX_W'(cols_eff) - SX_W'(wlen_q);
  assign col_last = (SX_W'(col_q) == cmax);
  assign row_last = (row_q == (rows_eff - RX_W'(1)));

  // Command decode of the accepted word
  assign is_load = cmd_i.accept && (in_word_i.command == CMD_LOAD);
  assign is_word = cmd_i.accept && (in_word_i.command == CMD_WORD);
  assign is_read = cmd_i.accept && (in_word_i.command == CMD_READ);

  assign in_grid   = (AD_W'(in_word_i.row) < AD_W'(ROWS_MAX)) &&
                     (AD_W'(in_word_i.column) < AD_W'(COLS_MAX));
  assign word_room = (wlen_q < WL_W'(WORD_MAX));

  // Grid addresses: host access and scan position
  assign in_addr   = GA_W'(in_word_i.row) * GA_W'(COLS_MAX) + GA_W'(in_word_i.column);
  assign scan_addr = GA_W'(row_q) * GA_W'(COLS_MAX) + GA_W'(col_q) + GA_W'(k_q);

  // Grid port steering
  assign g_we    = (is_load && in_grid) || cmd_i.mask_wr;
  assign g_waddr = cmd_i.mask_wr ? scan_addr : in_addr;
  assign g_wdata = cmd_i.mask_wr ? MASK_CHAR : in_word_i.char_value;
  assign g_re    = is_read || cmd_i.issue;
  assign g_raddr = cmd_i.issue ? scan_addr : in_addr;
  assign w_we    = is_word && word_room;

  grsm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (GD)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .re_i    (g_re),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  grsm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (WORD_MAX)
  ) u_word (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (wlen_q[WA_W-1:0]),
    .wdata_i (in_word_i.char_value),
    .re_i    (cmd_i.issue),
    .raddr_i (k_q[WA_W-1:0]),
    .rdata_o (w_rdata)
  );

  // Scan counters and match tally
  always_comb begin
    wlen_d = wlen_q;
    row_d  = row_q;
    col_d  = col_q;
    k_d    = k_q;
    hits_d = hits_q;
    if (cmd_i.clear_word) begin
      wlen_d = '0;
    end else if (w_we) begin
      wlen_d = wlen_q + WL_W'(1);
    end
    if (cmd_i.start_search) begin
      row_d  = '0;
      col_d  = '0;
      k_d    = '0;
      hits_d = '0;
    end else if (cmd_i.next_start) begin
      k_d = '0;
      if (col_last) begin
        col_d = '0;
        row_d = row_q + RX_W'(1);
      end else begin
        col_d = col_q + CX_W'(1);
      end
    end else if (cmd_i.hit) begin
      k_d = '0;
      if (hits_q != COUNT_LIMIT) begin
        hits_d = hits_q + COUNT_W'(1);
      end
    end else if (cmd_i.issue || cmd_i.mask_wr) begin
      k_d = k_q + WL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      k_q    <= '0;
      hits_q <= '0;
      chk_q  <= 1'b0;
    end else begin
      wlen_q <= wlen_d;
      row_q  <= row_d;
      col_q  <= col_d;
      k_q    <= k_d;
      hits_q <= hits_d;
      chk_q  <= cmd_i.issue;
    end
  end

  // Out-of-grid read flag
  always_ff @(posedge clk_i) begin
    if (is_read) begin
      rd_oor_q <= !in_grid;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_read) begin
      out_q.result_kind <= KIND_CELL;
      out_q.cell_value  <= rd_oor_q ? '0 : g_rdata;
      out_q.match_count <= '0;
    end else if (cmd_i.load_done) begin
      out_q.result_kind <= KIND_DONE;
      out_q.cell_value  <= '0;
      out_q.match_count <= hits_q;
    end
  end

  assign out_word_o = out_q;

  // Status towards the controller
  assign sts_o.search_empty = (wlen_q == '0) || (SX_W'(wlen_q) > SX_W'(cols_eff)) ||
                              (rows_eff == '0);
  assign sts_o.mismatch     = chk_q && (g_rdata != w_rdata);
  assign sts_o.chk_last     = chk_q && (g_rdata == w_rdata) && (k_q == wlen_q);
  assign sts_o.k_room       = (k_q < wlen_q);
  assign sts_o.mask_last    = (k_q == (wlen_q - WL_W'(1)));
  assign sts_o.last_start   = col_last && row_last;

  // A compare in flight always follows at least one issued read
  a_chk_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (k_q != '0))
    else $error("compare pending with no read issued");

  // A hit restarts the character index and drains the compare pipe
  a_hit_resets_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hit |=> ((k_q == '0) && !chk_q))
    else $error("index not cleared after hit");

  // Mask writes never run past the word
  a_mask_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mask_wr |-> (k_q < wlen_q))
    else $error("mask write beyond word length");

endmodule

/* sv/grsm_ctrl.sv */
module grsm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  grsm_pkg::in_word_t   in_word_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  grsm_pkg::dp_sts_t    sts_i,
  output grsm_pkg::ctrl_cmd_t  cmd_o
);

  import grsm_pkg::*;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      slot_free;
  ctrl_cmd_t cmd;

  assign slot_free = !out_valid_q || !out_stall_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          unique case (in_word_i.command)
            CMD_WORD: begin
              if (in_word_i.word_last) begin
                cmd.start_search = 1'b1;
                state_d          = ST_SETUP;
              end
            end
            CMD_READ: state_d = ST_READ;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) begin
          cmd.load_read = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_SETUP: begin
        state_d = sts_i.search_empty ? ST_DONE : ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.mismatch) begin
          if (sts_i.last_start) begin
            state_d = ST_DONE;
          end else begin
            cmd.next_start = 1'b1;
          end
        end else if (sts_i.chk_last) begin
          cmd.hit = 1'b1;
          state_d = ST_MASK;
        end else if (sts_i.k_room) begin
          cmd.issue = 1'b1;
        end
      end
      ST_MASK: begin
        cmd.mask_wr = 1'b1;
        if (sts_i.mask_last) begin
          if (sts_i.last_start) begin
            state_d = ST_DONE;
          end else begin
            cmd.next_start = 1'b1;
            state_d        = ST_CMP;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_done  = 1'b1;
          cmd.clear_word = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_read || cmd.load_done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // A result is only written into a free slot
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_read || cmd.load_done) |-> slot_free)
    else $error("result written over a waiting word");

  // A final word character always blocks the input while searching
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_word_i.command == CMD_WORD) &&
     in_word_i.word_last) |=> in_stall_o)
    else $error("input taken during search");

  // Grid read and mask write never share a cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.issue && cmd.mask_wr))
    else $error("scan read and mask write together");

endmodule

/* sv/grid_row_word_search_mask_top.sv */
// Channel  | Handshake                        | Word
// ---------+----------------------------------+----------------------
// input    | in_valid_i / in_stall_o          | grsm_pkg::in_word_t
// output   | out_valid_o / out_stall_i        | grsm_pkg::out_word_t
// config   | cfg_we_i, cfg_idx_i, cfg_data_i  | 7-bit register data
//
// Loads and ignored commands are taken while idle; a read is registered in the grid
// and loaded into the result register once the output slot is free. A final word
// character holds the input stalled for the scan: a setup state, then per start a
// character-by-character compare, mask writes over each match, and a finish state.
// Reset is asynchronous, active low; the grid and word stores are not cleared. A
// waiting result does not stop input until the next result is ready to be written.
module grid_row_word_search_mask_top #(
  parameter int ROWS_MAX = 64,
  parameter int COLS_MAX = 64,
  parameter int WORD_MAX = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [grsm_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [grsm_pkg::REG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  grsm_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output grsm_pkg::out_word_t         out_word_o
);

  import grsm_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer
  grsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Grid, word store and scan counters
  grsm_dp #(
    .ROWS_MAX (ROWS_MAX),
    .COLS_MAX (COLS_MAX),
    .WORD_MAX (WORD_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule
